[sv/circ_pkg.sv]
// Shared types and constants for the circle-from-three-points datapath.
// Used by every module of the block; depends on nothing.
package circ_pkg;

    // Defaults of the top-level parameters
    localparam int CIRC_COORD_FRAC_BITS = 16;
    localparam int CIRC_COORD_WIDTH     = 32;

    // Field and register widths
    localparam int COORD_W  = 32;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 1;

    // Datapath widths, fixed by the 32-bit coordinate fields
    localparam int DIFF_W    = 33;   // edge vector component
    localparam int PROD_W    = 66;   // product of two components
    localparam int DET_W     = 67;   // signed determinant
    localparam int DET_MAG_W = 66;   // |det|
    localparam int SQ_W      = 65;   // squared edge length
    localparam int TERM_W    = 99;   // component times squared length
    localparam int NUM_W     = 100;  // signed Cramer numerator
    localparam int NUM_MAG_W = 99;   // |numerator|
    localparam int DEN_W     = 67;   // |2*det|
    localparam int QBITS     = 41;   // quotient bits kept before the clamp
    localparam int QUOT_W    = 42;   // signed clamped quotient
    localparam int ROOT_W    = 32;   // square root result
    localparam int RAD_W     = 64;   // radicand

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DET_EPSILON = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 1'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] DET_EPSILON_RST = 31'd1;
    localparam logic [CFG_W-1:0] MIN_LENGTH_RST  = 31'd6554;

    // First point plus the collinear verdict
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic                      col;
    } circ_base_t;

    // Division operands handed from the front end to the divider
    typedef struct packed {
        logic [NUM_MAG_W-1:0] num_x;
        logic [NUM_MAG_W-1:0] num_y;
        logic [DEN_W-1:0]     den;
        logic                 neg_x;
        logic                 neg_y;
        circ_base_t           base;
    } circ_quot_t;

    // Center offsets handed from the divider to the root stage
    typedef struct packed {
        logic signed [QUOT_W-1:0] ux;
        logic signed [QUOT_W-1:0] uy;
        circ_base_t               base;
    } circ_cen_t;

    // Finished circle word
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] radius;
        logic [CFG_W-1:0]          trunk_length;
        logic                      collinear;
    } circ_res_t;

endpackage

[sv/circ_front.sv]
// Front end: edge vectors, determinant, collinear test and Cramer numerators.
// Eight register stages; depends on circ_pkg.
module circ_front import circ_pkg::*; #(
    parameter int COORD_WIDTH = CIRC_COORD_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [COORD_W-1:0] in_x1,
    input  logic [COORD_W-1:0] in_y1,
    input  logic [COORD_W-1:0] in_x2,
    input  logic [COORD_W-1:0] in_y2,
    input  logic [COORD_W-1:0] in_x3,
    input  logic [COORD_W-1:0] in_y3,
    input  logic [CFG_W-1:0]   det_epsilon,
    output logic               out_valid,
    output circ_quot_t         out_q
);

    function automatic logic signed [COORD_W-1:0] sext(input logic [COORD_W-1:0] v);
        return COORD_W'($signed(v[COORD_WIDTH-1:0]));
    endfunction

    logic [7:0] vld_reg;

    // stage 0: captured points
    logic signed [COORD_W-1:0] x1_0_reg, y1_0_reg, x2_0_reg, y2_0_reg, x3_0_reg, y3_0_reg;
    // stage 1: edge vectors
    logic signed [COORD_W-1:0] x1_1_reg, y1_1_reg;
    logic signed [DIFF_W-1:0]  ax_1_reg, ay_1_reg, bx_1_reg, by_1_reg;
    // stage 2: products
    logic signed [COORD_W-1:0] x1_2_reg, y1_2_reg;
    logic signed [DIFF_W-1:0]  ax_2_reg, ay_2_reg, bx_2_reg, by_2_reg;
    logic signed [PROD_W-1:0]  axby_reg, aybx_reg, axax_reg, ayay_reg, bxbx_reg, byby_reg;
    logic signed [PROD_W-1:0]  axby_next, aybx_next, axax_next, ayay_next, bxbx_next, byby_next;
    // stage 3: determinant and squared lengths
    logic signed [COORD_W-1:0] x1_3_reg, y1_3_reg;
    logic signed [DIFF_W-1:0]  ax_3_reg, ay_3_reg, bx_3_reg, by_3_reg;
    logic signed [DET_W-1:0]   det_reg, det_next;
    logic [SQ_W-1:0]           sa_reg, sb_reg;
    // stage 4: |det| and partial products of the numerators
    logic signed [COORD_W-1:0] x1_4_reg, y1_4_reg;
    logic [DET_MAG_W-1:0]      dmag_4_reg;
    logic                      dneg_4_reg;
    logic signed [DET_W-1:0]   det_abs;
    logic signed [PROD_W-1:0]  nxa_lo_reg, nxb_lo_reg, nya_lo_reg, nyb_lo_reg;
    logic signed [PROD_W-1:0]  nxa_lo_next, nxb_lo_next, nya_lo_next, nyb_lo_next;
    logic signed [DET_W-1:0]   nxa_hi_reg, nxb_hi_reg, nya_hi_reg, nyb_hi_reg;
    logic signed [DET_W-1:0]   nxa_hi_next, nxb_hi_next, nya_hi_next, nyb_hi_next;
    // stage 5: full terms and collinear flag
    logic signed [COORD_W-1:0] x1_5_reg, y1_5_reg;
    logic [DET_MAG_W-1:0]      dmag_5_reg;
    logic                      dneg_5_reg, col_5_reg;
    logic signed [TERM_W-1:0]  nxa_reg, nxb_reg, nya_reg, nyb_reg;
    // stage 6: signed numerators
    logic signed [COORD_W-1:0] x1_6_reg, y1_6_reg;
    logic [DET_MAG_W-1:0]      dmag_6_reg;
    logic                      dneg_6_reg, col_6_reg;
    logic signed [NUM_W-1:0]   num_x_reg, num_y_reg, num_x_next, num_y_next;
    // stage 7: magnitudes and quotient signs
    circ_quot_t                q_reg, q_next;
    logic signed [NUM_W-1:0]   num_x_abs, num_y_abs;

    // advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    // products and numerator partial products
    always_comb begin
        axby_next   = ax_1_reg * by_1_reg;
        aybx_next   = ay_1_reg * bx_1_reg;
        axax_next   = ax_1_reg * ax_1_reg;
        ayay_next   = ay_1_reg * ay_1_reg;
        bxbx_next   = bx_1_reg * bx_1_reg;
        byby_next   = by_1_reg * by_1_reg;
        det_next    = DET_W'(axby_reg) - DET_W'(aybx_reg);
        det_abs     = det_reg[DET_W-1] ? -det_reg : det_reg;
        nxa_lo_next = by_3_reg * $signed({1'b0, sa_reg[31:0]});
        nxb_lo_next = ay_3_reg * $signed({1'b0, sb_reg[31:0]});
        nya_lo_next = ax_3_reg * $signed({1'b0, sb_reg[31:0]});
        nyb_lo_next = bx_3_reg * $signed({1'b0, sa_reg[31:0]});
        nxa_hi_next = by_3_reg * $signed({1'b0, sa_reg[SQ_W-1:32]});
        nxb_hi_next = ay_3_reg * $signed({1'b0, sb_reg[SQ_W-1:32]});
        nya_hi_next = ax_3_reg * $signed({1'b0, sb_reg[SQ_W-1:32]});
        nyb_hi_next = bx_3_reg * $signed({1'b0, sa_reg[SQ_W-1:32]});
        num_x_next  = NUM_W'(nxa_reg) - NUM_W'(nxb_reg);
        num_y_next  = NUM_W'(nya_reg) - NUM_W'(nyb_reg);
    end

    // take magnitudes for the unsigned divider
    always_comb begin
        num_x_abs      = num_x_reg[NUM_W-1] ? -num_x_reg : num_x_reg;
        num_y_abs      = num_y_reg[NUM_W-1] ? -num_y_reg : num_y_reg;
        q_next.num_x   = num_x_abs[NUM_MAG_W-1:0];
        q_next.num_y   = num_y_abs[NUM_MAG_W-1:0];
        q_next.den     = {dmag_6_reg, 1'b0};
        q_next.neg_x   = num_x_reg[NUM_W-1] ^ dneg_6_reg;
        q_next.neg_y   = num_y_reg[NUM_W-1] ^ dneg_6_reg;
        q_next.base.x1 = x1_6_reg;
        q_next.base.y1 = y1_6_reg;
        q_next.base.col = col_6_reg;
    end

    // payload stages, held while stalled
    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_0_reg <= sext(in_x1);
            y1_0_reg <= sext(in_y1);
            x2_0_reg <= sext(in_x2);
            y2_0_reg <= sext(in_y2);
            x3_0_reg <= sext(in_x3);
            y3_0_reg <= sext(in_y3);

            x1_1_reg <= x1_0_reg;
            y1_1_reg <= y1_0_reg;
            ax_1_reg <= DIFF_W'(x2_0_reg) - DIFF_W'(x1_0_reg);
            ay_1_reg <= DIFF_W'(y2_0_reg) - DIFF_W'(y1_0_reg);
            bx_1_reg <= DIFF_W'(x3_0_reg) - DIFF_W'(x1_0_reg);
            by_1_reg <= DIFF_W'(y3_0_reg) - DIFF_W'(y1_0_reg);

            x1_2_reg <= x1_1_reg;
            y1_2_reg <= y1_1_reg;
            ax_2_reg <= ax_1_reg;
            ay_2_reg <= ay_1_reg;
            bx_2_reg <= bx_1_reg;
            by_2_reg <= by_1_reg;
            axby_reg <= axby_next;
            aybx_reg <= aybx_next;
            axax_reg <= axax_next;
            ayay_reg <= ayay_next;
            bxbx_reg <= bxbx_next;
            byby_reg <= byby_next;

            x1_3_reg <= x1_2_reg;
            y1_3_reg <= y1_2_reg;
            ax_3_reg <= ax_2_reg;
            ay_3_reg <= ay_2_reg;
            bx_3_reg <= bx_2_reg;
            by_3_reg <= by_2_reg;
            det_reg  <= det_next;
            sa_reg   <= {1'b0, axax_reg[63:0]} + {1'b0, ayay_reg[63:0]};
            sb_reg   <= {1'b0, bxbx_reg[63:0]} + {1'b0, byby_reg[63:0]};

            x1_4_reg   <= x1_3_reg;
            y1_4_reg   <= y1_3_reg;
            dmag_4_reg <= det_abs[DET_MAG_W-1:0];
            dneg_4_reg <= det_reg[DET_W-1];
            nxa_lo_reg <= nxa_lo_next;
            nxb_lo_reg <= nxb_lo_next;
            nya_lo_reg <= nya_lo_next;
            nyb_lo_reg <= nyb_lo_next;
            nxa_hi_reg <= nxa_hi_next;
            nxb_hi_reg <= nxb_hi_next;
            nya_hi_reg <= nya_hi_next;
            nyb_hi_reg <= nyb_hi_next;

            x1_5_reg   <= x1_4_reg;
            y1_5_reg   <= y1_4_reg;
            dmag_5_reg <= dmag_4_reg;
            dneg_5_reg <= dneg_4_reg;
            col_5_reg  <= (dmag_4_reg == '0) ||
                          (dmag_4_reg < {{(DET_MAG_W-CFG_W){1'b0}}, det_epsilon});
            nxa_reg    <= (TERM_W'(nxa_hi_reg) <<< 32) + TERM_W'(nxa_lo_reg);
            nxb_reg    <= (TERM_W'(nxb_hi_reg) <<< 32) + TERM_W'(nxb_lo_reg);
            nya_reg    <= (TERM_W'(nya_hi_reg) <<< 32) + TERM_W'(nya_lo_reg);
            nyb_reg    <= (TERM_W'(nyb_hi_reg) <<< 32) + TERM_W'(nyb_lo_reg);

            x1_6_reg   <= x1_5_reg;
            y1_6_reg   <= y1_5_reg;
            dmag_6_reg <= dmag_5_reg;
            dneg_6_reg <= dneg_5_reg;
            col_6_reg  <= col_5_reg;
            num_x_reg  <= num_x_next;
            num_y_reg  <= num_y_next;

            q_reg <= q_next;
        end
    end

    assign out_valid = vld_reg[7];
    assign out_q     = q_reg;

endmodule

[sv/circ_div.sv]
// Two-lane pipelined restoring divider for the center offsets, one
// quotient bit per stage, with the clamp and sign. Depends on circ_pkg.
module circ_div import circ_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic       in_valid,
    input  circ_quot_t in_q,
    output logic       out_valid,
    output circ_cen_t  out_c
);

    localparam int EXT_W = DEN_W + QBITS;

    typedef struct packed {
        logic [DEN_W-1:0] rem_x;
        logic [QBITS-1:0] nq_x;
        logic [DEN_W-1:0] rem_y;
        logic [QBITS-1:0] nq_y;
        logic [DEN_W-1:0] den;
        logic             ovf_x;
        logic             ovf_y;
        logic             neg_x;
        logic             neg_y;
        circ_base_t       base;
    } div_stage_t;

    // one restoring step: bring in the next numerator bit, subtract if it fits
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t     r;
        logic [DEN_W:0] tx;
        logic [DEN_W:0] ty;
        r  = s;
        tx = {s.rem_x, s.nq_x[QBITS-1]};
        ty = {s.rem_y, s.nq_y[QBITS-1]};
        if (tx >= {1'b0, s.den}) begin
            r.rem_x = DEN_W'(tx - {1'b0, s.den});
            r.nq_x  = {s.nq_x[QBITS-2:0], 1'b1};
        end else begin
            r.rem_x = tx[DEN_W-1:0];
            r.nq_x  = {s.nq_x[QBITS-2:0], 1'b0};
        end
        if (ty >= {1'b0, s.den}) begin
            r.rem_y = DEN_W'(ty - {1'b0, s.den});
            r.nq_y  = {s.nq_y[QBITS-2:0], 1'b1};
        end else begin
            r.rem_y = ty[DEN_W-1:0];
            r.nq_y  = {s.nq_y[QBITS-2:0], 1'b0};
        end
        return r;
    endfunction

    // clamp the magnitude to 2^40 and apply the sign
    function automatic logic signed [QUOT_W-1:0] clamp_sign(input logic [QBITS-1:0] q,
                                                           input logic ovf,
                                                           input logic neg);
        logic [QBITS-1:0] mag;
        logic signed [QUOT_W-1:0] sv;
        if (ovf || (q[QBITS-1] && (|q[QBITS-2:0]))) begin
            mag = {1'b1, {(QBITS-1){1'b0}}};
        end else begin
            mag = q;
        end
        sv = $signed({1'b0, mag});
        return neg ? -sv : sv;
    endfunction

    logic [QBITS+1:0] vld_reg;
    div_stage_t       st_reg  [0:QBITS];
    div_stage_t       st_next [1:QBITS];
    div_stage_t       init_next;
    circ_cen_t        c_reg, c_next;

    // load the partial remainders; flag quotients of 2^41 or more
    always_comb begin
        init_next.rem_x = {{(DEN_W-(NUM_MAG_W-QBITS)){1'b0}}, in_q.num_x[NUM_MAG_W-1:QBITS]};
        init_next.rem_y = {{(DEN_W-(NUM_MAG_W-QBITS)){1'b0}}, in_q.num_y[NUM_MAG_W-1:QBITS]};
        init_next.nq_x  = in_q.num_x[QBITS-1:0];
        init_next.nq_y  = in_q.num_y[QBITS-1:0];
        init_next.den   = in_q.den;
        init_next.ovf_x = {{(EXT_W-NUM_MAG_W){1'b0}}, in_q.num_x} >= {in_q.den, {QBITS{1'b0}}};
        init_next.ovf_y = {{(EXT_W-NUM_MAG_W){1'b0}}, in_q.num_y} >= {in_q.den, {QBITS{1'b0}}};
        init_next.neg_x = in_q.neg_x;
        init_next.neg_y = in_q.neg_y;
        init_next.base  = in_q.base;
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_step
        assign st_next[k] = div_step(st_reg[k-1]);
    end

    always_comb begin
        c_next.ux   = clamp_sign(st_reg[QBITS].nq_x, st_reg[QBITS].ovf_x, st_reg[QBITS].neg_x);
        c_next.uy   = clamp_sign(st_reg[QBITS].nq_y, st_reg[QBITS].ovf_y, st_reg[QBITS].neg_y);
        c_next.base = st_reg[QBITS].base;
    end

    // advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[QBITS:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= init_next;
            for (int k = 1; k <= QBITS; k++) begin
                st_reg[k] <= st_next[k];
            end
            c_reg <= c_next;
        end
    end

    assign out_valid = vld_reg[QBITS+1];
    assign out_c     = c_reg;

endmodule

[sv/circ_sqrt.sv]
// Center saturation, radicand and pipelined integer square root, one root
// bit per stage, then the final circle word. Depends on circ_pkg.
module circ_sqrt import circ_pkg::*; #(
    parameter int COORD_FRAC_BITS = CIRC_COORD_FRAC_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  circ_cen_t        in_c,
    input  logic [CFG_W-1:0] min_length,
    output logic             out_valid,
    output circ_res_t        out_res
);

    localparam logic signed [COORD_W-1:0] NEG_ONE = -(32'sd1 <<< COORD_FRAC_BITS);
    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;
    localparam int REM_W = ROOT_W + 2;
    localparam int SUM_W = COORD_W + 11;
    localparam int SQR_W = 2 * (COORD_W - 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic                      col;
        logic                      rsat;
    } tail_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [RAD_W-1:0]  vr;
        logic [ROOT_W-1:0] root;
        tail_t             tail;
    } sq_stage_t;

    // one root digit: bring in two radicand bits, subtract 4*root+1 if it fits
    function automatic sq_stage_t sq_step(input sq_stage_t s);
        sq_stage_t        r;
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        r     = s;
        t     = {s.rem, s.vr[RAD_W-1:RAD_W-2]};
        trial = {2'b00, s.root, 2'b01};
        r.vr  = {s.vr[RAD_W-3:0], 2'b00};
        if (t >= trial) begin
            r.rem  = REM_W'(t - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = t[REM_W-1:0];
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (v < SUM_W'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return v[COORD_W-1:0];
    endfunction

    logic [ROOT_W+2:0]         vld_reg;
    // first stage: saturated center, offset magnitudes
    logic [QBITS-1:0]          mag_x_reg, mag_y_reg;
    tail_t                     t1_reg;
    logic signed [QUOT_W-1:0]  ux_abs, uy_abs;
    // second stage: squares
    logic [SQR_W-1:0]          sq_x_reg, sq_y_reg;
    tail_t                     t2_reg;
    sq_stage_t                 st_reg  [0:ROOT_W];
    sq_stage_t                 st_next [1:ROOT_W];
    sq_stage_t                 init_next;
    logic signed [COORD_W-1:0] rad;
    logic [ROOT_W-1:0]         root_fin;
    tail_t                     tail_fin;

    always_comb begin
        ux_abs = in_c.ux[QUOT_W-1] ? -in_c.ux : in_c.ux;
        uy_abs = in_c.uy[QUOT_W-1] ? -in_c.uy : in_c.uy;
        init_next.rem  = '0;
        init_next.vr   = {1'b0, {1'b0, sq_x_reg} + {1'b0, sq_y_reg}};
        init_next.root = '0;
        init_next.tail = t2_reg;
    end

    for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
        assign st_next[k] = sq_step(st_reg[k-1]);
    end

    // advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[ROOT_W+1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_x_reg   <= ux_abs[QBITS-1:0];
            mag_y_reg   <= uy_abs[QBITS-1:0];
            t1_reg.cx   <= sat32(SUM_W'(in_c.base.x1) + SUM_W'(in_c.ux));
            t1_reg.cy   <= sat32(SUM_W'(in_c.base.y1) + SUM_W'(in_c.uy));
            t1_reg.col  <= in_c.base.col;
            t1_reg.rsat <= 1'b0;

            sq_x_reg    <= mag_x_reg[COORD_W-2:0] * mag_x_reg[COORD_W-2:0];
            sq_y_reg    <= mag_y_reg[COORD_W-2:0] * mag_y_reg[COORD_W-2:0];
            t2_reg.cx   <= t1_reg.cx;
            t2_reg.cy   <= t1_reg.cy;
            t2_reg.col  <= t1_reg.col;
            t2_reg.rsat <= (|mag_x_reg[QBITS-1:COORD_W-1]) || (|mag_y_reg[QBITS-1:COORD_W-1]);

            st_reg[0] <= init_next;
            for (int k = 1; k <= ROOT_W; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // format the circle word
    always_comb begin
        root_fin = st_reg[ROOT_W].root;
        tail_fin = st_reg[ROOT_W].tail;
        if (tail_fin.rsat || root_fin[ROOT_W-1]) begin
            rad = SAT_MAX;
        end else begin
            rad = $signed(root_fin);
        end
        if (tail_fin.col) begin
            out_res.center_x     = '0;
            out_res.center_y     = '0;
            out_res.radius       = NEG_ONE;
            out_res.trunk_length = '0;
            out_res.collinear    = 1'b1;
        end else begin
            out_res.center_x     = tail_fin.cx;
            out_res.center_y     = tail_fin.cy;
            out_res.radius       = rad;
            out_res.trunk_length = (rad[CFG_W-1:0] > min_length) ? rad[CFG_W-1:0] : min_length;
            out_res.collinear    = 1'b0;
        end
    end

    assign out_valid = vld_reg[ROOT_W+2];

endmodule

[sv/circle_from_three_points_unit.sv]
// Circle through three Q16.16 points: center, radius, trunk length.
// Takes three points on the s_ channel and returns one circle word per
// point triple on the m_ channel, in order. Both channels are valid/ready.
// A triple is accepted when s_valid and s_ready are high at a clock edge;
// a new triple can be taken in every cycle while the output keeps up.
// On its way from acceptance to m_valid a triple passes 8 front-end stages
// (products, determinant, numerators), 43 divider stages (one quotient bit
// per stage over 41 bits), 35 root stages (one root bit per stage over 32
// bits) and then the output buffer register.
// The output buffer holds two words, so a stalled receiver freezes the
// pipeline only once both are full; s_ready then drops and nothing is lost.
// Configuration: cfg_wr_en with cfg_index writes det_epsilon (0) or
// min_length (1) from cfg_wr_data; write them only while the block is idle.
// Synchronous active-low reset empties the pipeline and restores the
// register defaults (det_epsilon 1, min_length 6554).
// Depends on circ_pkg, circ_front, circ_div and circ_sqrt.
module circle_from_three_points_unit import circ_pkg::*; #(
    parameter int COORD_FRAC_BITS = CIRC_COORD_FRAC_BITS,
    parameter int COORD_WIDTH     = CIRC_COORD_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_first_x,
    input  logic signed [COORD_W-1:0] s_first_y,
    input  logic signed [COORD_W-1:0] s_second_x,
    input  logic signed [COORD_W-1:0] s_second_y,
    input  logic signed [COORD_W-1:0] s_third_x,
    input  logic signed [COORD_W-1:0] s_third_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_center_x,
    output logic signed [COORD_W-1:0] m_center_y,
    output logic signed [COORD_W-1:0] m_radius,
    output logic [CFG_W-1:0]          m_trunk_length,
    output logic                      m_collinear
);

    localparam logic signed [COORD_W-1:0] NEG_ONE = -(32'sd1 <<< COORD_FRAC_BITS);

    logic [CFG_W-1:0] det_eps_reg, min_len_reg;
    logic             adv;
    logic             q_valid, c_valid, pipe_valid;
    circ_quot_t       q_word;
    circ_cen_t        c_word;
    circ_res_t        pipe_res;
    circ_res_t        head_reg, head_next, tail_reg, tail_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_eps_reg <= DET_EPSILON_RST;
            min_len_reg <= MIN_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DET_EPSILON: det_eps_reg <= cfg_wr_data;
                REG_MIN_LENGTH:  min_len_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // the whole pipeline advances while the output buffer has room
    assign adv     = (cnt_reg != 2'd2);
    assign s_ready = adv;

    circ_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (s_valid),
        .in_x1       (s_first_x),
        .in_y1       (s_first_y),
        .in_x2       (s_second_x),
        .in_y2       (s_second_y),
        .in_x3       (s_third_x),
        .in_y3       (s_third_y),
        .det_epsilon (det_eps_reg),
        .out_valid   (q_valid),
        .out_q       (q_word)
    );

    circ_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (q_valid),
        .in_q      (q_word),
        .out_valid (c_valid),
        .out_c     (c_word)
    );

    circ_sqrt #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_sqrt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (c_valid),
        .in_c       (c_word),
        .min_length (min_len_reg),
        .out_valid  (pipe_valid),
        .out_res    (pipe_res)
    );

    // two-word output buffer: push finished words, pop on the handshake
    assign push = pipe_valid && adv;
    assign pop  = (cnt_reg != 2'd0) && m_ready;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (push && !pop) begin
            if (cnt_reg == 2'd0) begin
                head_next = pipe_res;
            end else begin
                tail_next = pipe_res;
            end
            cnt_next = 2'(cnt_reg + 2'd1);
        end else if (pop && !push) begin
            head_next = tail_reg;
            cnt_next  = 2'(cnt_reg - 2'd1);
        end else if (push && pop) begin
            head_next = pipe_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_valid        = (cnt_reg != 2'd0);
    assign m_center_x     = head_reg.center_x;
    assign m_center_y     = head_reg.center_y;
    assign m_radius       = head_reg.radius;
    assign m_trunk_length = head_reg.trunk_length;
    assign m_collinear    = head_reg.collinear;

    // buffer never overfills
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    // buffer comes out of reset empty
    a_cnt_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> cnt_reg == 2'd0)
        else $error("output buffer not empty after reset");

    // a collinear word carries the fixed marker values
    a_col_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_collinear |-> m_radius == NEG_ONE && m_trunk_length == '0 &&
        m_center_x == '0 && m_center_y == '0)
        else $error("collinear word with wrong fields");

endmodule
